// ----- rtl/core/framed_byte_ring_buffer_macros.svh -----
// assertion macros for the framed byte ring buffer checker
`ifndef FRAMED_BYTE_RING_BUFFER_MACROS_SVH
`define FRAMED_BYTE_RING_BUFFER_MACROS_SVH

// checked outside reset only
`define FBRB_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fbrb check failed");

// checked at every edge, reset included
`define FBRB_CHECK_RAW(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fbrb reset check failed");

`endif

// ----- rtl/core/fbrb_pkg.sv -----
// shared types and constants of the framed byte ring buffer
package fbrb_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int RING_W      = PTR_W + 1;
  localparam int CFG_W       = 13;
  localparam int LEN_W       = 12;
  localparam int CMP_W       = (CFG_W > RING_W) ? CFG_W : RING_W;
  localparam int RING_RESET  = (4096 > STORE_DEPTH) ? STORE_DEPTH : 4096;

  localparam logic [7:0] HDR_FIRST  = 8'hA5;
  localparam logic [7:0] HDR_SECOND = 8'hBF;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_DROP   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_LEN_LO = 2'd1;
  localparam logic [1:0] PH_LEN_HI = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_FIRST = 2'd1,
    OP_NEXT  = 2'd2
  } op_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload_byte;
    logic             frame_first;
    logic [LEN_W-1:0] frame_length;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        last_of_frame;
    logic [15:0] length_seen;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } req_t;

endpackage

// ----- rtl/core/fbrb_front.sv -----
// front end: accepts requests, classifies them and queues them for the engine
module fbrb_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  fbrb_pkg::item_t item,
  output logic           req_valid,
  output fbrb_pkg::req_t req,
  input  logic           req_ready
);

  fbrb_pkg::req_t slot [2];
  logic           head;
  logic [1:0]     count;
  logic           tail;
  logic           push_fire;
  logic           pop_fire;
  fbrb_pkg::req_t classified;

  assign full      = (count == 2'd2);
  assign req_valid = (count != 2'd0);
  assign req       = slot[head];
  assign tail      = head ^ count[0];
  assign push_fire = push && !full;
  assign pop_fire  = req_valid && req_ready;

  always_comb begin
    classified.data = item.payload_byte;
    classified.len  = item.frame_length;
    if (item.kind == fbrb_pkg::KIND_READ) begin
      classified.op = fbrb_pkg::OP_READ;
    end else if (item.frame_first) begin
      classified.op = fbrb_pkg::OP_FIRST;
    end else begin
      classified.op = fbrb_pkg::OP_NEXT;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot[tail] <= classified;
    end
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      head  <= head ^ pop_fire;
      count <= count + 2'(push_fire) - 2'(pop_fire);
    end
  end

endmodule

// ----- rtl/core/fbrb_back.sv -----
// back end: ring store, write and read sequencers, result queue
module fbrb_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  fbrb_pkg::req_t              req,
  output logic                        req_ready,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fbrb_pkg::CFG_W-1:0]  cfg_data,
  output logic                        empty,
  input  logic                        pop,
  output fbrb_pkg::result_t           result
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_WRITE    = 4'b0010,
    S_RD_ISSUE = 4'b0100,
    S_RD_DATA  = 4'b1000
  } state_t;

  localparam logic [2:0] WR_LAST = 3'd4;

  state_t                          state;
  logic [fbrb_pkg::RING_W-1:0]     ring_size;
  logic [fbrb_pkg::PTR_W-1:0]      wp;
  logic [fbrb_pkg::PTR_W-1:0]      rp;
  logic [fbrb_pkg::LEN_W-1:0]      wr_rem;
  logic                            wr_drop;
  logic [2:0]                      wr_idx;
  logic [fbrb_pkg::LEN_W-1:0]      wr_len;
  logic [7:0]                      wr_data;
  logic [1:0]                      rd_phase;
  logic [7:0]                      prev_byte;
  logic [15:0]                     rd_rem;
  logic [15:0]                     len_reg;
  logic [7:0]                      mem [fbrb_pkg::STORE_DEPTH];
  logic [7:0]                      rdata;

  fbrb_pkg::result_t               oq [2];
  logic                            oq_head;
  logic [1:0]                      oq_count;

  logic [fbrb_pkg::PTR_W-1:0]      wp_step;
  logic [fbrb_pkg::PTR_W-1:0]      rp_step;
  logic                            store_full;
  logic                            store_empty;
  logic                            take;
  logic                            len_ok;
  logic [7:0]                      wr_byte;
  logic                            mem_we;
  logic                            res_push;
  fbrb_pkg::result_t               res_val;
  logic                            pop_fire;
  logic [fbrb_pkg::RING_W-1:0]     cfg_ring;
  logic [15:0]                     len_full;

  function automatic logic [fbrb_pkg::PTR_W-1:0] next_slot(
    input logic [fbrb_pkg::PTR_W-1:0]  p,
    input logic [fbrb_pkg::RING_W-1:0] rs
  );
    logic [fbrb_pkg::CMP_W-1:0] inc;
    inc = fbrb_pkg::CMP_W'(p) + fbrb_pkg::CMP_W'(1);
    if (inc >= fbrb_pkg::CMP_W'(rs)) begin
      return '0;
    end
    return fbrb_pkg::PTR_W'(inc);
  endfunction

  assign wp_step     = next_slot(wp, ring_size);
  assign rp_step     = next_slot(rp, ring_size);
  assign store_full  = (ring_size == '0) || (wp_step == rp);
  assign store_empty = (ring_size == '0) || (rp == wp);
  assign req_ready   = (state == S_IDLE) && (oq_count != 2'd2);
  assign cfg_ready   = (state == S_IDLE);
  assign take        = req_valid && req_ready;
  assign len_ok      = (req.len != '0) &&
                       (fbrb_pkg::CMP_W'(req.len) + fbrb_pkg::CMP_W'(4)
                        <= fbrb_pkg::CMP_W'(ring_size));
  assign mem_we      = (state == S_WRITE) && !store_full;
  assign len_full    = {rdata, len_reg[7:0]};
  assign cfg_ring    = (fbrb_pkg::CMP_W'(cfg_data) > fbrb_pkg::CMP_W'(fbrb_pkg::STORE_DEPTH))
                       ? fbrb_pkg::RING_W'(fbrb_pkg::STORE_DEPTH)
                       : fbrb_pkg::RING_W'(cfg_data);

  assign empty    = (oq_count == 2'd0);
  assign result   = oq[oq_head];
  assign pop_fire = pop && !empty;

  always_comb begin
    case (wr_idx)
      3'd0:    wr_byte = fbrb_pkg::HDR_FIRST;
      3'd1:    wr_byte = fbrb_pkg::HDR_SECOND;
      3'd2:    wr_byte = wr_len[7:0];
      3'd3:    wr_byte = 8'(wr_len >> 8);
      default: wr_byte = wr_data;
    endcase
  end

  always_comb begin
    res_push = 1'b0;
    res_val  = '0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (req.op)
            fbrb_pkg::OP_FIRST: begin
              if (!len_ok) begin
                res_push       = 1'b1;
                res_val.status = fbrb_pkg::ST_REJECT;
              end
            end
            fbrb_pkg::OP_NEXT: begin
              if (wr_rem == '0 || wr_drop) begin
                res_push       = 1'b1;
                res_val.status = fbrb_pkg::ST_DROP;
              end
            end
            default: ;
          endcase
        end
      end
      S_WRITE: begin
        if (store_full) begin
          res_push       = 1'b1;
          res_val.status = fbrb_pkg::ST_DROP;
        end else if (wr_idx == WR_LAST) begin
          res_push       = 1'b1;
          res_val.status = fbrb_pkg::ST_OK;
        end
      end
      S_RD_ISSUE: begin
        if (store_empty) begin
          res_push       = 1'b1;
          res_val.status = fbrb_pkg::ST_EMPTY;
        end
      end
      S_RD_DATA: begin
        if (rd_phase == fbrb_pkg::PH_DATA) begin
          res_push              = 1'b1;
          res_val.read_byte     = rdata;
          res_val.last_of_frame = (rd_rem == 16'd1);
          res_val.length_seen   = len_reg;
          res_val.status        = fbrb_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= wr_byte;
    end
    if (state == S_RD_ISSUE) begin
      rdata <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq[oq_head ^ oq_count[0]] <= res_val;
    end
    if (rst) begin
      oq_head  <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      oq_head  <= oq_head ^ pop_fire;
      oq_count <= oq_count + 2'(res_push) - 2'(pop_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready)) begin
      state     <= S_IDLE;
      wp        <= '0;
      rp        <= '0;
      wr_rem    <= '0;
      wr_drop   <= 1'b0;
      wr_idx    <= '0;
      rd_phase  <= fbrb_pkg::PH_HUNT;
      prev_byte <= '0;
      rd_rem    <= '0;
      len_reg   <= '0;
      if (rst) begin
        ring_size <= fbrb_pkg::RING_W'(fbrb_pkg::RING_RESET);
      end else begin
        ring_size <= cfg_ring;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (req.op)
              fbrb_pkg::OP_FIRST: begin
                if (!len_ok) begin
                  wr_rem  <= '0;
                  wr_drop <= 1'b0;
                end else begin
                  wr_rem  <= req.len - fbrb_pkg::LEN_W'(1);
                  wr_len  <= req.len;
                  wr_data <= req.data;
                  wr_idx  <= '0;
                  state   <= S_WRITE;
                end
              end
              fbrb_pkg::OP_NEXT: begin
                if (wr_rem != '0) begin
                  wr_rem <= wr_rem - fbrb_pkg::LEN_W'(1);
                  if (!wr_drop) begin
                    wr_data <= req.data;
                    wr_idx  <= WR_LAST;
                    state   <= S_WRITE;
                  end
                end
              end
              default: state <= S_RD_ISSUE;
            endcase
          end
        end
        S_WRITE: begin
          if (store_full) begin
            wr_drop <= 1'b1;
            state   <= S_IDLE;
          end else begin
            wp <= wp_step;
            if (wr_idx == WR_LAST) begin
              wr_drop <= 1'b0;
              state   <= S_IDLE;
            end else begin
              wr_idx <= wr_idx + 3'd1;
            end
          end
        end
        S_RD_ISSUE: begin
          if (store_empty) begin
            rd_phase  <= fbrb_pkg::PH_HUNT;
            prev_byte <= '0;
            rd_rem    <= '0;
            len_reg   <= '0;
            state     <= S_IDLE;
          end else begin
            rp    <= rp_step;
            state <= S_RD_DATA;
          end
        end
        S_RD_DATA: begin
          unique case (rd_phase)
            fbrb_pkg::PH_HUNT: begin
              if (prev_byte == fbrb_pkg::HDR_FIRST && rdata == fbrb_pkg::HDR_SECOND) begin
                rd_phase  <= fbrb_pkg::PH_LEN_LO;
                prev_byte <= '0;
              end else begin
                prev_byte <= rdata;
              end
              state <= S_RD_ISSUE;
            end
            fbrb_pkg::PH_LEN_LO: begin
              len_reg  <= {8'h00, rdata};
              rd_phase <= fbrb_pkg::PH_LEN_HI;
              state    <= S_RD_ISSUE;
            end
            fbrb_pkg::PH_LEN_HI: begin
              len_reg  <= len_full;
              rd_rem   <= len_full;
              rd_phase <= (len_full == '0) ? fbrb_pkg::PH_HUNT : fbrb_pkg::PH_DATA;
              state    <= S_RD_ISSUE;
            end
            default: begin
              rd_rem <= rd_rem - 16'd1;
              if (rd_rem == 16'd1) begin
                rd_phase <= fbrb_pkg::PH_HUNT;
              end
              state <= S_IDLE;
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/framed_byte_ring_buffer.sv -----
// Framed byte ring buffer, top level. Requests enter through a two-deep front queue
// and results leave through a two-deep result queue, so either side may stall on its
// own. The engine serves one request at a time over a single-port byte store with a
// registered read. A continuation write stores its payload byte. A frame-opening
// write stores the two header bytes, two length bytes and the payload byte one per
// cycle; a write that meets a full store ends in the cycle it finds it full.
// Rejected frames, stray bytes and bytes of a frame that is already dropping are
// answered from the idle state without a store write. A read consumes stored bytes
// (header hunt, length bytes, skipped zero-length frames, then the payload byte),
// each through a read issue state and a data state; a read that finds the store
// empty ends in its read issue state. The ring_size register is accepted only while
// the engine is idle; writing it empties the store. No clearing pass follows reset.
module framed_byte_ring_buffer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  fbrb_pkg::item_t             item,
  output logic                        empty,
  input  logic                        pop,
  output fbrb_pkg::result_t           result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fbrb_pkg::CFG_W-1:0]  cfg_data
);

  logic           req_valid;
  logic           req_ready;
  fbrb_pkg::req_t req;

  fbrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  fbrb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ----- rtl/core/fbrb_checker.sv -----
// port-level checks of the framed byte ring buffer and their binding
`include "framed_byte_ring_buffer_macros.svh"

module fbrb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        push,
  input logic                        full,
  input fbrb_pkg::item_t             item,
  input logic                        empty,
  input logic                        pop,
  input fbrb_pkg::result_t           result,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [fbrb_pkg::CFG_W-1:0]  cfg_data
);

  logic unused_ports;
  assign unused_ports = push ^ (^item) ^ cfg_valid ^ cfg_ready ^ (^cfg_data);

  `FBRB_CHECK_RAW(a_reset_clears, rst |=> empty && !full)
  `FBRB_CHECK(a_empty_read_zero, !empty && result.status == fbrb_pkg::ST_EMPTY |-> result.read_byte == 8'h00 && !result.last_of_frame && result.length_seen == 16'h0000)
  `FBRB_CHECK(a_last_is_ok, !empty && result.last_of_frame |-> result.status == fbrb_pkg::ST_OK)
  `FBRB_CHECK(a_result_holds, !empty && !pop |=> !empty && $stable(result))

endmodule

bind framed_byte_ring_buffer fbrb_checker u_fbrb_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .item      (item),
  .empty     (empty),
  .pop       (pop),
  .result    (result),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);

// ----- test/framed_byte_ring_buffer_checker.sv -----
`timescale 1ns / 1ps
// checker that predicts framed byte ring buffer results and compares them at the result port
module framed_byte_ring_buffer_checker
  import fbrb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  item_t            item,
  input  logic             pop,
  input  logic             empty,
  input  result_t          result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int               outstanding,
  output int               mismatches
);

  logic [7:0] ring_bytes [0:STORE_DEPTH-1];
  int         slots;
  int         wr_ptr;
  int         rd_ptr;
  int         wr_left;
  bit         wr_drop;
  logic [1:0] rd_phase;
  logic [7:0] prior_byte;
  int         rd_left;
  int         len_reg;
  result_t    awaited [$];

  function automatic void clear_sequencers();
    wr_ptr     = 0;
    rd_ptr     = 0;
    wr_left    = 0;
    wr_drop    = 1'b0;
    rd_phase   = PH_HUNT;
    prior_byte = '0;
    rd_left    = 0;
    len_reg    = 0;
  endfunction

  function automatic int next_slot(int p);
    return (p + 1 >= slots) ? 0 : p + 1;
  endfunction

  function automatic bit put_byte(logic [7:0] b);
    bit stored;
    stored = 1'b0;
    if (slots != 0 && next_slot(wr_ptr) != rd_ptr) begin
      ring_bytes[wr_ptr % STORE_DEPTH] = b;
      wr_ptr = next_slot(wr_ptr);
      stored = 1'b1;
    end
    return stored;
  endfunction

  function automatic bit take_byte(output logic [7:0] b);
    bit taken;
    taken = 1'b0;
    b = '0;
    if (slots != 0 && rd_ptr != wr_ptr) begin
      b = ring_bytes[rd_ptr % STORE_DEPTH];
      rd_ptr = next_slot(rd_ptr);
      taken = 1'b1;
    end
    return taken;
  endfunction

  function automatic result_t store_step(item_t it);
    result_t    r;
    logic [7:0] b;
    bit         settled;
    r = '0;
    settled = 1'b0;
    if (it.kind == KIND_WRITE) begin
      if (it.frame_first) begin
        if (it.frame_length == 0 || int'(it.frame_length) + 4 > slots) begin
          wr_left  = 0;
          wr_drop  = 1'b0;
          r.status = ST_REJECT;
        end else begin
          wr_left = int'(it.frame_length) - 1;
          wr_drop = !(put_byte(HDR_FIRST) && put_byte(HDR_SECOND) &&
                      put_byte(it.frame_length[7:0]) &&
                      put_byte({4'h0, it.frame_length[11:8]}) &&
                      put_byte(it.payload_byte));
          r.status = wr_drop ? ST_DROP : ST_OK;
        end
      end else if (wr_left == 0) begin
        r.status = ST_DROP;
      end else begin
        wr_left--;
        if (wr_drop) begin
          r.status = ST_DROP;
        end else if (!put_byte(it.payload_byte)) begin
          wr_drop  = 1'b1;
          r.status = ST_DROP;
        end
      end
    end else begin
      while (!settled) begin
        if (!take_byte(b)) begin
          rd_phase   = PH_HUNT;
          prior_byte = '0;
          rd_left    = 0;
          len_reg    = 0;
          r.status   = ST_EMPTY;
          settled    = 1'b1;
        end else begin
          case (rd_phase)
            PH_HUNT: begin
              if (prior_byte == HDR_FIRST && b == HDR_SECOND) begin
                rd_phase   = PH_LEN_LO;
                prior_byte = '0;
              end else begin
                prior_byte = b;
              end
            end
            PH_LEN_LO: begin
              len_reg  = int'(b);
              rd_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              len_reg  = len_reg | (int'(b) << 8);
              rd_left  = len_reg;
              rd_phase = (len_reg == 0) ? PH_HUNT : PH_DATA;
            end
            default: begin
              rd_left--;
              r.read_byte     = b;
              r.last_of_frame = (rd_left == 0);
              r.length_seen   = len_reg[15:0];
              if (rd_left == 0) rd_phase = PH_HUNT;
              settled = 1'b1;
            end
          endcase
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      slots = RING_RESET;
      clear_sequencers();
      awaited.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slots = (cfg_data > STORE_DEPTH) ? STORE_DEPTH : int'(cfg_data);
        clear_sequencers();
      end
      if (push && !full) awaited.push_back(store_step(item));
      if (pop && !empty) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("result %h with no request waiting", result));
        end else begin
          want = awaited.pop_front();
          if (result.read_byte !== want.read_byte)
            report_mismatch($sformatf("read_byte got %h want %h",
                                      result.read_byte, want.read_byte));
          if (result.last_of_frame !== want.last_of_frame)
            report_mismatch($sformatf("last_of_frame got %b want %b",
                                      result.last_of_frame, want.last_of_frame));
          if (result.length_seen !== want.length_seen)
            report_mismatch($sformatf("length_seen got %h want %h",
                                      result.length_seen, want.length_seen));
          if (result.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      result.status, want.status));
        end
      end
    end
    outstanding <= awaited.size();
  end

endmodule

// ----- test/tb_framed_byte_ring_buffer.sv -----
`timescale 1ns / 1ps
// testbench top that drives requests, result pops and ring size writes into the ring buffer
module tb_framed_byte_ring_buffer;
  import fbrb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic             clk;
  logic             rst       = 1'b1;
  logic             push      = 1'b0;
  item_t            item      = '0;
  logic             pop       = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             full;
  logic             empty;
  logic             cfg_ready;
  result_t          result;
  int               outstanding;
  int               mismatches;
  int               cycles      = 0;
  int               pop_hold    = 0;
  bit               pop_steady  = 1'b0;
  bit               push_steady = 1'b0;
  int               sent        = 0;

  framed_byte_ring_buffer u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  framed_byte_ring_buffer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .pop         (pop),
    .empty       (empty),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side stalls and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("framed_byte_ring_buffer: mismatch");
      $finish;
    end
    if (cycles % 300 == 0) pop_steady <= ($urandom_range(0, 3) == 0);
    if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (!pop_steady && $urandom_range(0, 3) == 0) begin
      pop      <= 1'b0;
      pop_hold <= ($urandom_range(0, 15) == 0) ? int'($urandom_range(10, 40))
                                                : int'($urandom_range(0, 2));
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic push_item(logic k, logic [7:0] d, logic f, logic [LEN_W-1:0] l);
    int gap;
    gap = 0;
    if (!push_steady && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 15) == 0) ? int'($urandom_range(10, 40))
                                          : int'($urandom_range(1, 3));
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= item_t'{kind: k, payload_byte: d, frame_first: f, frame_length: l};
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic read_req();
    push_item(KIND_READ, 8'($urandom), 1'($urandom), LEN_W'($urandom));
  endtask

  task automatic open_frame(logic [LEN_W-1:0] len, logic [7:0] d);
    push_item(KIND_WRITE, d, 1'b1, len);
  endtask

  task automatic frame_byte(logic [7:0] d);
    push_item(KIND_WRITE, d, 1'b0, LEN_W'($urandom));
  endtask

  // waits until every request has its result
  task automatic quiesce();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_ring(logic [CFG_W-1:0] v);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_length();
    return ($urandom_range(0, 15) == 0) ? int'($urandom_range(17, 90))
                                         : int'($urandom_range(1, 16));
  endfunction

  task automatic random_traffic(int n);
    int stop;
    int len;
    stop = sent + n;
    while (sent < stop) begin
      push_steady = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6)) read_req();
        1: frame_byte(8'($urandom));
        2: open_frame(LEN_W'($urandom), 8'($urandom));
        3: begin
          // frame that may be cut short
          len = pick_length();
          open_frame(LEN_W'(len), 8'($urandom));
          repeat ($urandom_range(0, len - 1)) frame_byte(8'($urandom));
        end
        default: begin
          len = pick_length();
          open_frame(LEN_W'(len), 8'($urandom));
          for (int i = 1; i < len; i++) begin
            if ($urandom_range(0, 2) != 0) read_req();
            frame_byte(8'($urandom));
          end
          repeat ($urandom_range(0, 2)) read_req();
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    read_req();
    frame_byte(8'h5A);
    open_frame(12'd0, 8'h01);
    open_frame(12'hFFF, 8'hFF);
    open_frame(12'd3, 8'h00);
    frame_byte(8'hFF);
    frame_byte(HDR_FIRST);
    frame_byte(8'h33);
    repeat (4) read_req();
    // partial frame discarded, then a zero length header left for the reader to skip
    open_frame(12'd6, 8'h11);
    read_req();
    read_req();
    frame_byte(HDR_FIRST);
    frame_byte(HDR_SECOND);
    frame_byte(8'h00);
    frame_byte(8'h00);
    open_frame(12'd1, 8'h77);
    read_req();
    open_frame(12'd2, 8'hC3);
    open_frame(12'd1, 8'h3C);
    repeat (3) read_req();

    random_traffic(175);
    quiesce();
    random_traffic(175);

    set_ring(13'd8);
    random_traffic(120);
    set_ring(13'd5);
    random_traffic(60);
    set_ring(13'd0);
    random_traffic(40);
    set_ring(13'h1FFF);
    random_traffic(280);
    set_ring(13'd13);
    random_traffic(120);
    set_ring(13'd1);
    random_traffic(30);
    set_ring(13'd4097);
    random_traffic(100);
    set_ring(13'd64);
    random_traffic(230);
    set_ring(13'd4096);
    random_traffic(50);

    quiesce();
    if (mismatches == 0) $display("framed_byte_ring_buffer: match");
    else $display("framed_byte_ring_buffer: mismatch");
    $finish;
  end

endmodule
